// ===== sv/bfu_pkg.sv =====
package bfu_pkg;

  // Field widths of the ports.
  localparam int CFG_W   = 13;
  localparam int COORD_W = 12;
  localparam int ADDR_W  = 19;
  localparam int RGB_W   = 24;
  localparam int ARGB_W  = 32;
  localparam int WGT_W   = 8;

  // Default source frame size.
  localparam int DEF_SRC_WIDTH  = 640;
  localparam int DEF_SRC_HEIGHT = 480;

  // Reset values of the output frame size registers.
  localparam logic [CFG_W-1:0] OUT_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] OUT_HEIGHT_RST = 13'd480;

  // Coordinate mapping: 26-bit product, 28-bit saturated quotient.
  localparam int PROD_W              = 26;
  localparam int QUOT_W              = 28;
  localparam int DIV_STEPS_PER_STAGE = 4;
  localparam int DIV_STAGES          = QUOT_W / DIV_STEPS_PER_STAGE;
  localparam logic [QUOT_W-1:0] HALF_PIXEL = 28'h0008000;

  // Queue depths between the parts and towards the result port.
  localparam int FRONT_QUEUE_DEPTH  = 16;
  localparam int RESULT_QUEUE_DEPTH = 8;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_OUT_WIDTH  = 1'b0,
    REG_OUT_HEIGHT = 1'b1
  } cfg_reg_t;

  // Input item kinds.
  typedef enum logic [0:0] {
    MODE_WRITE   = 1'b0,
    MODE_REQUEST = 1'b1
  } mode_t;

  // Classified item passed from the front part to the back part.
  typedef struct packed {
    logic               is_req;
    logic [ADDR_W-1:0]  addr;
    logic [RGB_W-1:0]   rgb;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic               x_edge;
    logic               y_edge;
    logic [WGT_W-1:0]   wx;
    logic [WGT_W-1:0]   wy;
  } item_t;

  // Blend two RGB words channel by channel with an 8-bit weight.
  function automatic logic [RGB_W-1:0] blend_rgb(logic [RGB_W-1:0] a,
                                                 logic [RGB_W-1:0] b,
                                                 logic [WGT_W-1:0] t);
    logic [RGB_W-1:0] res;
    logic [8:0]       s;
    logic [16:0]      sum;
    s = 9'd256 - {1'b0, t};
    for (int c = 0; c < 3; c++) begin
      sum = ({9'b0, a[c*8 +: 8]} * {8'b0, s}) + ({9'b0, b[c*8 +: 8]} * {8'b0, 1'b0, t});
      res[c*8 +: 8] = sum[15:8];
    end
    return res;
  endfunction

endpackage

// ===== sv/bfu_fifo.sv =====
module bfu_fifo #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             is_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      if (wr_en && !rd_en) begin
        count <= CNT_W'(count + 1'b1);
      end else if (rd_en && !wr_en) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

  assign rd_data  = mem[rd_ptr];
  assign is_empty = (count == '0);

endmodule

// ===== sv/bfu_ram.sv =====
module bfu_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 24
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr_a,
  input  logic [ADDR_W-1:0] rd_addr_b,
  output logic [DATA_W-1:0] rd_data_a,
  output logic [DATA_W-1:0] rd_data_b
);

  logic [DATA_W-1:0] mem [DEPTH];

  // One write port and two registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// ===== sv/bfu_front.sv =====
module bfu_front #(
  parameter int SRC_WIDTH  = bfu_pkg::DEF_SRC_WIDTH,
  parameter int SRC_HEIGHT = bfu_pkg::DEF_SRC_HEIGHT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [0:0]                  cfg_index,
  input  logic [bfu_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  input  logic                        mode,
  input  logic [bfu_pkg::ADDR_W-1:0]  src_addr,
  input  logic [bfu_pkg::RGB_W-1:0]   pixel_rgb,
  input  logic [bfu_pkg::COORD_W-1:0] out_x,
  input  logic [bfu_pkg::COORD_W-1:0] out_y,
  output logic                        item_valid,
  output bfu_pkg::item_t              item
);

  localparam int NSTG = bfu_pkg::DIV_STAGES;
  localparam int QW   = bfu_pkg::QUOT_W;
  localparam logic [12:0]   SRC_X  = 13'(SRC_WIDTH);
  localparam logic [12:0]   SRC_Y  = 13'(SRC_HEIGHT);
  localparam logic [QW-1:0] MAX_X  = QW'((SRC_WIDTH - 1) * 65536);
  localparam logic [QW-1:0] MAX_Y  = QW'((SRC_HEIGHT - 1) * 65536);
  localparam logic [11:0]   EDGE_X = 12'(SRC_WIDTH - 1);
  localparam logic [11:0]   EDGE_Y = 12'(SRC_HEIGHT - 1);

  // Division state of one axis.
  typedef struct packed {
    logic [12:0]   r;
    logic [QW-1:0] d;
    logic [QW-1:0] q;
    logic          ov;
  } div_t;

  typedef struct packed {
    logic                        is_req;
    logic [bfu_pkg::ADDR_W-1:0]  addr;
    logic [bfu_pkg::RGB_W-1:0]   rgb;
    div_t                        x;
    div_t                        y;
  } div_stage_t;

  // A few restoring division steps on one axis.
  function automatic div_t div_step(div_t s, logic [12:0] n);
    div_t        o;
    logic [13:0] r14;
    o = s;
    for (int k = 0; k < bfu_pkg::DIV_STEPS_PER_STAGE; k++) begin
      r14 = {o.r, o.d[QW-1]};
      o.d = {o.d[QW-2:0], 1'b0};
      if (r14 >= {1'b0, n}) begin
        o.r = 13'(r14 - {1'b0, n});
        o.q = {o.q[QW-2:0], 1'b1};
      end else begin
        o.r = r14[12:0];
        o.q = {o.q[QW-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  function automatic div_stage_t stage_step(div_stage_t s, logic [12:0] nx, logic [12:0] ny);
    div_stage_t o;
    o   = s;
    o.x = div_step(s.x, nx);
    o.y = div_step(s.y, ny);
    return o;
  endfunction

  // Take off the half pixel and clamp to the source edge.
  function automatic logic [QW-1:0] clamp_pos(div_t s, logic [QW-1:0] maxp);
    logic [QW-1:0] p;
    if (s.ov) begin
      p = maxp;
    end else if (s.q < bfu_pkg::HALF_PIXEL) begin
      p = '0;
    end else begin
      p = s.q - bfu_pkg::HALF_PIXEL;
      if (p > maxp) begin
        p = maxp;
      end
    end
    return p;
  endfunction

  function automatic div_t div_init(logic [bfu_pkg::PROD_W-1:0] p, logic [12:0] n);
    div_t o;
    o.r  = p[25:13];
    o.ov = (p[25:13] >= n);
    o.d  = {p[12:0], 15'b0};
    o.q  = '0;
    return o;
  endfunction

  logic [bfu_pkg::CFG_W-1:0] out_width;
  logic [bfu_pkg::CFG_W-1:0] out_height;
  logic [12:0]               n_x;
  logic [12:0]               n_y;

  logic                        a_valid;
  logic                        a_req;
  logic [bfu_pkg::ADDR_W-1:0]  a_addr;
  logic [bfu_pkg::RGB_W-1:0]   a_rgb;
  logic [bfu_pkg::COORD_W-1:0] a_ox;
  logic [bfu_pkg::COORD_W-1:0] a_oy;

  logic                         b_valid;
  logic                         b_req;
  logic [bfu_pkg::ADDR_W-1:0]   b_addr;
  logic [bfu_pkg::RGB_W-1:0]    b_rgb;
  logic [bfu_pkg::PROD_W-1:0]   b_px;
  logic [bfu_pkg::PROD_W-1:0]   b_py;

  div_stage_t       dv_in;
  div_stage_t       dv_data [1:NSTG];
  logic [NSTG:1]    dv_valid;

  logic [QW-1:0]    pos_x;
  logic [QW-1:0]    pos_y;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_width  <= bfu_pkg::OUT_WIDTH_RST;
      out_height <= bfu_pkg::OUT_HEIGHT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bfu_pkg::REG_OUT_WIDTH:  out_width  <= cfg_data;
        bfu_pkg::REG_OUT_HEIGHT: out_height <= cfg_data;
      endcase
    end
  end

  // A zero output size counts as one.
  assign n_x = (out_width == '0) ? 13'd1 : out_width;
  assign n_y = (out_height == '0) ? 13'd1 : out_height;

  // Valid bits of the front pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid    <= 1'b0;
      b_valid    <= 1'b0;
      dv_valid   <= '0;
      item_valid <= 1'b0;
    end else begin
      a_valid    <= in_valid;
      b_valid    <= a_valid;
      dv_valid   <= {dv_valid[NSTG-1:1], b_valid};
      item_valid <= dv_valid[NSTG];
    end
  end

  // Input register and pixel-centre products (2o+1)*SRC.
  always_ff @(posedge clk) begin
    a_req  <= (mode == bfu_pkg::MODE_REQUEST);
    a_addr <= src_addr;
    a_rgb  <= pixel_rgb;
    a_ox   <= out_x;
    a_oy   <= out_y;
    b_req  <= a_req;
    b_addr <= a_addr;
    b_rgb  <= a_rgb;
    b_px   <= {13'b0, a_ox, 1'b1} * {13'b0, SRC_X};
    b_py   <= {13'b0, a_oy, 1'b1} * {13'b0, SRC_Y};
  end

  // Start of the division, with saturation when the quotient overflows.
  always_comb begin
    dv_in.is_req = b_req;
    dv_in.addr   = b_addr;
    dv_in.rgb    = b_rgb;
    dv_in.x      = div_init(b_px, n_x);
    dv_in.y      = div_init(b_py, n_y);
  end

  // Division pipeline, a few quotient bits per stage.
  always_ff @(posedge clk) begin
    dv_data[1] <= stage_step(dv_in, n_x, n_y);
    for (int s = 2; s <= NSTG; s++) begin
      dv_data[s] <= stage_step(dv_data[s-1], n_x, n_y);
    end
  end

  assign pos_x = clamp_pos(dv_data[NSTG].x, MAX_X);
  assign pos_y = clamp_pos(dv_data[NSTG].y, MAX_Y);

  // Integer positions, weights and edge flags.
  always_ff @(posedge clk) begin
    item.is_req <= dv_data[NSTG].is_req;
    item.addr   <= dv_data[NSTG].addr;
    item.rgb    <= dv_data[NSTG].rgb;
    item.x0     <= pos_x[27:16];
    item.y0     <= pos_y[27:16];
    item.x_edge <= (pos_x[27:16] == EDGE_X);
    item.y_edge <= (pos_y[27:16] == EDGE_Y);
    item.wx     <= pos_x[15:8];
    item.wy     <= pos_y[15:8];
  end

endmodule

// ===== sv/bfu_back.sv =====
module bfu_back #(
  parameter int SRC_WIDTH  = bfu_pkg::DEF_SRC_WIDTH,
  parameter int SRC_HEIGHT = bfu_pkg::DEF_SRC_HEIGHT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        issue,
  input  bfu_pkg::item_t              item,
  output logic                        res_valid,
  output logic [bfu_pkg::ARGB_W-1:0]  res_argb
);

  localparam int FRAME = SRC_WIDTH * SRC_HEIGHT;
  localparam int FA_W  = $clog2(FRAME);
  localparam logic [24:0]     ROW_W   = 25'(SRC_WIDTH);
  localparam logic [24:0]     FRAME_W = 25'(FRAME);
  localparam logic [FA_W-1:0] ROW_A   = FA_W'(SRC_WIDTH);

  bfu_pkg::item_t it0;
  logic           v0;

  logic [24:0]     row_sum;
  logic [24:0]     wr_wide;
  logic [FA_W-1:0] base;

  logic                       v1;
  logic                       req1;
  logic                       we1;
  logic [FA_W-1:0]            waddr1;
  logic [bfu_pkg::RGB_W-1:0]  wdata1;
  logic [FA_W-1:0]            a00;
  logic [FA_W-1:0]            a01;
  logic [FA_W-1:0]            a10;
  logic [FA_W-1:0]            a11;
  logic [bfu_pkg::WGT_W-1:0]  wx1;
  logic [bfu_pkg::WGT_W-1:0]  wy1;

  logic                       v2;
  logic [bfu_pkg::WGT_W-1:0]  wx2;
  logic [bfu_pkg::WGT_W-1:0]  wy2;
  logic [bfu_pkg::RGB_W-1:0]  p00;
  logic [bfu_pkg::RGB_W-1:0]  p01;
  logic [bfu_pkg::RGB_W-1:0]  p10;
  logic [bfu_pkg::RGB_W-1:0]  p11;

  logic                       v3;
  logic [bfu_pkg::WGT_W-1:0]  wy3;
  logic [bfu_pkg::RGB_W-1:0]  top3;
  logic [bfu_pkg::RGB_W-1:0]  bot3;

  // Valid bits of the back pipeline; after the memory stage only requests remain.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      v0        <= issue;
      v1        <= v0;
      v2        <= v1 && req1;
      v3        <= v2;
      res_valid <= v3;
    end
  end

  // Item taken from the queue.
  always_ff @(posedge clk) begin
    if (issue) begin
      it0 <= item;
    end
  end

  // Linear addresses of the four neighbours; an edge repeats the edge pixel.
  assign row_sum = ({13'b0, it0.y0} * ROW_W) + {13'b0, it0.x0};
  assign base    = row_sum[FA_W-1:0];
  assign wr_wide = {6'b0, it0.addr};

  always_ff @(posedge clk) begin
    req1   <= it0.is_req;
    we1    <= !it0.is_req && (wr_wide < FRAME_W);
    waddr1 <= wr_wide[FA_W-1:0];
    wdata1 <= it0.rgb;
    a00    <= base;
    a01    <= it0.x_edge ? base : FA_W'(base + 1'b1);
    a10    <= it0.y_edge ? base : FA_W'(base + ROW_A);
    a11    <= FA_W'((it0.y_edge ? base : FA_W'(base + ROW_A)) + (it0.x_edge ? 1'b0 : 1'b1));
    wx1    <= it0.wx;
    wy1    <= it0.wy;
  end

  // Two copies of the frame give four reads per cycle.
  bfu_ram #(
    .DEPTH  (FRAME),
    .ADDR_W (FA_W),
    .DATA_W (bfu_pkg::RGB_W)
  ) u_ram_top (
    .clk       (clk),
    .wr_en     (v1 && we1),
    .wr_addr   (waddr1),
    .wr_data   (wdata1),
    .rd_en     (v1 && req1),
    .rd_addr_a (a00),
    .rd_addr_b (a01),
    .rd_data_a (p00),
    .rd_data_b (p01)
  );

  bfu_ram #(
    .DEPTH  (FRAME),
    .ADDR_W (FA_W),
    .DATA_W (bfu_pkg::RGB_W)
  ) u_ram_bot (
    .clk       (clk),
    .wr_en     (v1 && we1),
    .wr_addr   (waddr1),
    .wr_data   (wdata1),
    .rd_en     (v1 && req1),
    .rd_addr_a (a10),
    .rd_addr_b (a11),
    .rd_data_a (p10),
    .rd_data_b (p11)
  );

  // Weights follow the memory read.
  always_ff @(posedge clk) begin
    wx2 <= wx1;
    wy2 <= wy1;
  end

  // Horizontal blend on both rows.
  always_ff @(posedge clk) begin
    top3 <= bfu_pkg::blend_rgb(p00, p01, wx2);
    bot3 <= bfu_pkg::blend_rgb(p10, p11, wx2);
    wy3  <= wy2;
  end

  // Vertical blend and opaque alpha.
  always_ff @(posedge clk) begin
    res_argb <= {bfu_pkg::ALPHA_OPAQUE, bfu_pkg::blend_rgb(top3, bot3, wy3)};
  end

endmodule

// ===== sv/bilinear_frame_upscaler_top.sv =====
// Bilinear frame upscaler. Source pixels are written one per transaction
// (mode 0) into a SRC_WIDTH x SRC_HEIGHT frame held in two on-chip copies;
// a request transaction (mode 1) returns one interpolated ARGB pixel of an
// out_width x out_height output frame, in request order. The block takes one
// transaction per clock while not full and returns one result per clock while
// popped: the coordinate mapping runs in a pipelined divider of 7 stages, the
// memory reads and blends in a 5-stage back pipeline, and a 16-entry queue
// separates the two. Writes give no result and take effect for every later
// request. The frame holds no defined data until written, so only written
// pixels should be requested.
module bilinear_frame_upscaler_top #(
  parameter int SRC_WIDTH  = bfu_pkg::DEF_SRC_WIDTH,
  parameter int SRC_HEIGHT = bfu_pkg::DEF_SRC_HEIGHT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [0:0]                  cfg_index,
  input  logic [bfu_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        push,
  output logic                        full,
  input  logic                        mode,
  input  logic [bfu_pkg::ADDR_W-1:0]  src_addr,
  input  logic [bfu_pkg::RGB_W-1:0]   pixel_rgb,
  input  logic [bfu_pkg::COORD_W-1:0] out_x,
  input  logic [bfu_pkg::COORD_W-1:0] out_y,
  input  logic                        pop,
  output logic                        empty,
  output logic [bfu_pkg::ARGB_W-1:0]  out_argb
);

  localparam int QD    = bfu_pkg::FRONT_QUEUE_DEPTH;
  localparam int RD    = bfu_pkg::RESULT_QUEUE_DEPTH;
  localparam int QC_W  = $clog2(QD + 1);
  localparam int RC_W  = $clog2(RD + 1);
  localparam int ITEM_W = $bits(bfu_pkg::item_t);

  logic           accept;
  logic           f_valid;
  bfu_pkg::item_t f_item;
  logic           q_empty;
  logic           q_pop;
  bfu_pkg::item_t q_item;
  logic           b_valid;
  logic [bfu_pkg::ARGB_W-1:0] b_argb;
  logic           res_pop;

  logic [QC_W-1:0] q_used;
  logic [RC_W-1:0] r_used;

  assign accept  = push && !full;
  assign full    = (q_used >= QC_W'(QD));
  assign res_pop = pop && !empty;
  assign q_pop   = !q_empty && (r_used < RC_W'(RD));

  // Queue credits: items in the front pipeline plus those waiting in the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_used <= '0;
    end else if (accept && !q_pop) begin
      q_used <= QC_W'(q_used + 1'b1);
    end else if (q_pop && !accept) begin
      q_used <= QC_W'(q_used - 1'b1);
    end
  end

  // Result credits: requests in the back pipeline plus results not yet taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      r_used <= '0;
    end else if ((q_pop && q_item.is_req) && !res_pop) begin
      r_used <= RC_W'(r_used + 1'b1);
    end else if (res_pop && !(q_pop && q_item.is_req)) begin
      r_used <= RC_W'(r_used - 1'b1);
    end
  end

  bfu_front #(
    .SRC_WIDTH  (SRC_WIDTH),
    .SRC_HEIGHT (SRC_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (accept),
    .mode       (mode),
    .src_addr   (src_addr),
    .pixel_rgb  (pixel_rgb),
    .out_x      (out_x),
    .out_y      (out_y),
    .item_valid (f_valid),
    .item       (f_item)
  );

  bfu_fifo #(
    .DEPTH (QD),
    .WIDTH (ITEM_W)
  ) u_item_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (f_valid),
    .wr_data  (f_item),
    .rd_en    (q_pop),
    .rd_data  (q_item),
    .is_empty (q_empty)
  );

  bfu_back #(
    .SRC_WIDTH  (SRC_WIDTH),
    .SRC_HEIGHT (SRC_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .issue     (q_pop),
    .item      (q_item),
    .res_valid (b_valid),
    .res_argb  (b_argb)
  );

  bfu_fifo #(
    .DEPTH (RD),
    .WIDTH (bfu_pkg::ARGB_W)
  ) u_result_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (b_valid),
    .wr_data  (b_argb),
    .rd_en    (res_pop),
    .rd_data  (out_argb),
    .is_empty (empty)
  );

endmodule

// ===== sv/bfu_checker.sv =====
module bfu_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       push,
  input logic                       full,
  input logic                       pop,
  input logic                       empty,
  input logic [bfu_pkg::ARGB_W-1:0] out_argb
);

  // Reset leaves no result waiting.
  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result waiting right after reset");

  // A result that is not taken stays on the ports unchanged.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_argb)))
    else $error("waiting result changed or vanished");

  // Every result is opaque.
  a_alpha_opaque: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (out_argb[31:24] == bfu_pkg::ALPHA_OPAQUE))
    else $error("result alpha is not opaque");

  // No result is waiting right after reset is released.
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    ($past(rst) && !rst) |=> empty)
    else $error("result appeared before any request could finish");

endmodule

bind bilinear_frame_upscaler_top bfu_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .push     (push),
  .full     (full),
  .pop      (pop),
  .empty    (empty),
  .out_argb (out_argb)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int SRC_W     = bfu_pkg::DEF_SRC_WIDTH;
  localparam int SRC_H     = bfu_pkg::DEF_SRC_HEIGHT;
  localparam int PIXELS    = SRC_W * SRC_H;
  localparam int SETTLE    = 40;
  localparam int N_ITEMS   = 1750;
  localparam int N_PHASES  = 8;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_write = 1'b0;
  logic [0:0]                   cfg_index = '0;
  logic [bfu_pkg::CFG_W-1:0]    cfg_data = '0;
  logic                         push = 1'b0;
  logic                         full;
  logic                         mode = 1'b0;
  logic [bfu_pkg::ADDR_W-1:0]   src_addr = '0;
  logic [bfu_pkg::RGB_W-1:0]    pixel_rgb = '0;
  logic [bfu_pkg::COORD_W-1:0]  out_x = '0;
  logic [bfu_pkg::COORD_W-1:0]  out_y = '0;
  logic                         pop = 1'b0;
  logic                         empty;
  logic [bfu_pkg::ARGB_W-1:0]   out_argb;

  // Shadow of the frame and of the size registers.
  logic [bfu_pkg::RGB_W-1:0]    frame_copy [int];
  logic [bfu_pkg::CFG_W-1:0]    width_copy;
  logic [bfu_pkg::CFG_W-1:0]    height_copy;
  logic [bfu_pkg::ARGB_W-1:0]   pixels_due [$];
  int                           errors = 0;
  bit                           calm = 1'b0;

  typedef struct {
    bfu_pkg::mode_t              kind;
    logic [bfu_pkg::ADDR_W-1:0]  addr;
    logic [bfu_pkg::RGB_W-1:0]   rgb;
    logic [bfu_pkg::COORD_W-1:0] x;
    logic [bfu_pkg::COORD_W-1:0] y;
    bit                          known;
    logic [bfu_pkg::ARGB_W-1:0]  argb;
  } row_t;

  bilinear_frame_upscaler_top uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #3ms;
    $display("FAILED: results differ");
    $finish;
  end

  // Map an output coordinate to a clamped 16.16 source position.
  function automatic longint source_pos(int o, logic [bfu_pkg::CFG_W-1:0] size, int src);
    longint n, num, pos, top;
    n = (size == 0) ? 1 : longint'(size);
    num = (longint'(2 * o + 1) * longint'(src)) <<< 15;
    pos = num / n - 32768;
    top = longint'(src - 1) * 65536;
    if (pos < 0) pos = 0;
    if (pos > top) pos = top;
    return pos;
  endfunction

  function automatic logic [bfu_pkg::RGB_W-1:0] mix(logic [bfu_pkg::RGB_W-1:0] a,
                                                    logic [bfu_pkg::RGB_W-1:0] b,
                                                    int t);
    logic [bfu_pkg::RGB_W-1:0] r;
    int c;
    for (c = 0; c < 3; c++)
      r[c*8 +: 8] = 8'((int'(a[c*8 +: 8]) * (256 - t) + int'(b[c*8 +: 8]) * t) >> 8);
    return r;
  endfunction

  function automatic logic [bfu_pkg::RGB_W-1:0] stored(int px, int py);
    int idx;
    idx = py * SRC_W + px;
    return frame_copy.exists(idx) ? frame_copy[idx] : '0;
  endfunction

  // Neighbour corner and weights of an output pixel.
  function automatic void corner(int ox, int oy, output int x0, output int y0,
                                 output int x1, output int y1, output int wx,
                                 output int wy);
    longint fx, fy;
    fx = source_pos(ox, width_copy, SRC_W);
    fy = source_pos(oy, height_copy, SRC_H);
    x0 = int'(fx >>> 16);
    y0 = int'(fy >>> 16);
    x1 = (x0 + 1 < SRC_W) ? x0 + 1 : x0;
    y1 = (y0 + 1 < SRC_H) ? y0 + 1 : y0;
    wx = int'((fx >>> 8) & 255);
    wy = int'((fy >>> 8) & 255);
  endfunction

  function automatic logic [bfu_pkg::ARGB_W-1:0] interpolate(int ox, int oy);
    int x0, y0, x1, y1, wx, wy;
    logic [bfu_pkg::RGB_W-1:0] upper, lower;
    corner(ox, oy, x0, y0, x1, y1, wx, wy);
    upper = mix(stored(x0, y0), stored(x1, y0), wx);
    lower = mix(stored(x0, y1), stored(x1, y1), wx);
    return {bfu_pkg::ALPHA_OPAQUE, mix(upper, lower, wy)};
  endfunction

  // Offer one transaction and update the shadow once it is taken.
  task automatic offer(row_t r);
    while (!calm && $urandom_range(99) < 16) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push      <= 1'b1;
    mode      <= r.kind;
    src_addr  <= r.addr;
    pixel_rgb <= r.rgb;
    out_x     <= r.x;
    out_y     <= r.y;
    do @(posedge clk); while (full);
    if (r.kind == bfu_pkg::MODE_WRITE) begin
      if (r.addr < PIXELS) frame_copy[int'(r.addr)] = r.rgb;
    end else begin
      pixels_due.push_back(r.known ? r.argb : interpolate(r.x, r.y));
    end
  endtask

  task automatic write_pixel(int idx, logic [bfu_pkg::RGB_W-1:0] rgb);
    row_t r;
    r = '{bfu_pkg::MODE_WRITE, bfu_pkg::ADDR_W'(idx), rgb, bfu_pkg::COORD_W'($urandom),
          bfu_pkg::COORD_W'($urandom), 0, '0};
    offer(r);
  endtask

  // Request a pixel, first writing any neighbour not yet written.
  task automatic ask_pixel(int ox, int oy);
    int x0, y0, x1, y1, wx, wy, k, idx;
    int spots [4];
    row_t r;
    // The coordinate ports carry only the low bits.
    ox = int'(bfu_pkg::COORD_W'(ox));
    oy = int'(bfu_pkg::COORD_W'(oy));
    corner(ox, oy, x0, y0, x1, y1, wx, wy);
    spots = '{y0 * SRC_W + x0, y0 * SRC_W + x1, y1 * SRC_W + x0, y1 * SRC_W + x1};
    for (k = 0; k < 4; k++) begin
      idx = spots[k];
      if (!frame_copy.exists(idx) || $urandom_range(9) == 0)
        write_pixel(idx, bfu_pkg::RGB_W'($urandom));
    end
    r = '{bfu_pkg::MODE_REQUEST, bfu_pkg::ADDR_W'($urandom), bfu_pkg::RGB_W'($urandom),
          bfu_pkg::COORD_W'(ox), bfu_pkg::COORD_W'(oy), 0, '0};
    offer(r);
  endtask

  // Wait for the block to drain before a register write.
  task automatic drain();
    push <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_size(logic [bfu_pkg::CFG_W-1:0] w, logic [bfu_pkg::CFG_W-1:0] h);
    cfg_write <= 1'b1;
    cfg_index <= bfu_pkg::REG_OUT_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= bfu_pkg::REG_OUT_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_write <= 1'b0;
    width_copy  = w;
    height_copy = h;
  endtask

  // Result side: compare every transaction with the oldest expectation.
  always @(posedge clk) begin
    logic [bfu_pkg::ARGB_W-1:0] want;
    if (!rst && pop && !empty) begin
      if (pixels_due.size() == 0) begin
        $error("out_argb: no result expected, actual %08h", out_argb);
        errors++;
      end else begin
        want = pixels_due.pop_front();
        if (out_argb !== want) begin
          $error("out_argb: expected %08h, actual %08h", want, out_argb);
          errors++;
        end
      end
    end
    pop <= calm || ($urandom_range(99) >= 16);
  end

  initial begin
    row_t script [$];
    logic [bfu_pkg::CFG_W-1:0] widths [N_PHASES];
    logic [bfu_pkg::CFG_W-1:0] heights [N_PHASES];
    int p, n, ox, oy;

    width_copy  = bfu_pkg::OUT_WIDTH_RST;
    height_copy = bfu_pkg::OUT_HEIGHT_RST;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset sizes, where mapping is one to one.
    script = '{
      '{bfu_pkg::MODE_WRITE, 19'd0, 24'hFFFFFF, '0, '0, 0, '0},
      '{bfu_pkg::MODE_WRITE, 19'd1, 24'h000000, '0, '0, 0, '0},
      '{bfu_pkg::MODE_WRITE, 19'(SRC_W), 24'hAAAAAA, '0, '0, 0, '0},
      '{bfu_pkg::MODE_WRITE, 19'(SRC_W + 1), 24'h555555, '0, '0, 0, '0},
      '{bfu_pkg::MODE_WRITE, 19'(PIXELS - 1), 24'h123456, '0, '0, 0, '0},
      '{bfu_pkg::MODE_WRITE, 19'(SRC_W - 1), 24'h0F0F0F, '0, '0, 0, '0},
      '{bfu_pkg::MODE_WRITE, 19'(2 * SRC_W - 1), 24'hF0F0F0, '0, '0, 0, '0},
      '{bfu_pkg::MODE_WRITE, 19'h7FFFF, 24'h000000, '0, '0, 0, '0},
      '{bfu_pkg::MODE_WRITE, 19'(PIXELS), 24'h000000, '0, '0, 0, '0},
      '{bfu_pkg::MODE_REQUEST, '0, '0, 12'd0, 12'd0, 1, 32'hFFFFFFFF},
      '{bfu_pkg::MODE_REQUEST, '1, '1, 12'hFFF, 12'hFFF, 1, 32'hFF123456},
      '{bfu_pkg::MODE_REQUEST, '0, '0, 12'hFFF, 12'd0, 0, '0},
      '{bfu_pkg::MODE_REQUEST, '0, '0, 12'd0, 12'd0, 1, 32'hFFFFFFFF}
    };
    foreach (script[i]) offer(script[i]);

    // Random phases, each under a different output size.
    widths  = '{13'd1, 13'd4096, 13'd8191, 13'd0, 13'd1280, 13'd3, 13'd0, 13'd0};
    heights = '{13'd1, 13'd4096, 13'd8191, 13'd0, 13'd960, 13'd7, 13'd0, 13'd0};
    widths[6]  = 13'($urandom_range(1, 4096));
    heights[6] = 13'($urandom_range(1, 4096));
    widths[7]  = 13'd640;
    heights[7] = 13'd480;
    for (p = 0; p < N_PHASES; p++) begin
      drain();
      set_size(widths[p], heights[p]);
      calm = (p == 4);
      for (n = 0; n < N_ITEMS / (N_PHASES * 3); n++) begin
        if ($urandom_range(9) == 0) begin
          write_pixel($urandom_range(0, (1 << bfu_pkg::ADDR_W) - 1),
                      bfu_pkg::RGB_W'($urandom));
        end else begin
          if ($urandom_range(3) == 0) begin
            ox = $urandom_range(0, 4095);
            oy = $urandom_range(0, 4095);
          end else begin
            ox = $urandom_range(0, (widths[p] > 1) ? widths[p] - 1 : 1);
            oy = $urandom_range(0, (heights[p] > 1) ? heights[p] - 1 : 1);
          end
          ask_pixel(ox, oy);
        end
      end
    end
    calm = 1'b0;
    push <= 1'b0;

    while (pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && pixels_due.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
